### src/ssp_pkg.sv
package ssp_pkg;

    localparam int PatternMax = 32;
    localparam int HistDepth  = PatternMax;
    localparam int LenW       = 6;
    localparam int IdxW       = $clog2(HistDepth);
    localparam int AddrW      = 6;
    localparam int DataW      = 64;

    localparam logic [2:0] RegLength     = 3'd0;
    localparam logic [2:0] RegPatternLow = 3'd1;
    localparam logic [2:0] RegPatternSec = 3'd2;
    localparam logic [2:0] RegPatternThd = 3'd3;
    localparam logic [2:0] RegPatternHi  = 3'd4;

    localparam logic KindData  = 1'b0;
    localparam logic KindRearm = 1'b1;

    typedef struct packed {
        logic [LenW-1:0]         length;
        logic [8*PatternMax-1:0] pattern;
    } cfg_t;

    function automatic logic [7:0] pattern_byte(input logic [8*PatternMax-1:0] pattern,
                                                input logic [IdxW-1:0] idx);
        pattern_byte = pattern[8*idx +: 8];
    endfunction

endpackage

### src/ssp_cell.sv
module ssp_cell (
    input  logic       clk,
    input  logic       shift,
    input  logic [7:0] byte_in,
    input  logic [7:0] pat_byte,
    input  logic       active,
    output logic [7:0] byte_q,
    output logic       hit
);

    logic [7:0] byte_reg;
    logic [7:0] byte_next;

    assign byte_next = shift ? byte_in : byte_reg;

    always_ff @(posedge clk)
    begin
        byte_reg <= byte_next;
    end

    assign byte_q = byte_reg;
    // an unused cell never blocks a match
    assign hit    = !active || (byte_reg == pat_byte);

endmodule

### src/ssp_cfg.sv
module ssp_cfg (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [ssp_pkg::AddrW-1:0]  paddr,
    input  logic [ssp_pkg::DataW-1:0]  pwdata,
    output logic [ssp_pkg::DataW-1:0]  prdata,
    output logic                       pready,
    output ssp_pkg::cfg_t              cfg
);

    logic [ssp_pkg::LenW-1:0] length_reg;
    logic [ssp_pkg::LenW-1:0] length_next;
    logic [63:0]              pat_reg  [4];
    logic [63:0]              pat_next [4];
    logic [2:0]               idx;
    logic                     wr;

    assign pready = 1'b1;
    assign idx    = paddr[5:3];
    assign wr     = psel && penable && pwrite;

    always_comb
    begin
        length_next = length_reg;
        for (int k = 0; k < 4; k++)
        begin
            pat_next[k] = pat_reg[k];
        end
        if (wr)
        begin
            unique case (idx)
                ssp_pkg::RegLength:     length_next = pwdata[ssp_pkg::LenW-1:0];
                ssp_pkg::RegPatternLow: pat_next[0] = pwdata;
                ssp_pkg::RegPatternSec: pat_next[1] = pwdata;
                ssp_pkg::RegPatternThd: pat_next[2] = pwdata;
                ssp_pkg::RegPatternHi:  pat_next[3] = pwdata;
                default:                length_next = length_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            length_reg <= '0;
            for (int k = 0; k < 4; k++)
            begin
                pat_reg[k] <= '0;
            end
        end
        else
        begin
            length_reg <= length_next;
            for (int k = 0; k < 4; k++)
            begin
                pat_reg[k] <= pat_next[k];
            end
        end
    end

    always_comb
    begin
        unique case (idx)
            ssp_pkg::RegLength:     prdata = {{(ssp_pkg::DataW-ssp_pkg::LenW){1'b0}}, length_reg};
            ssp_pkg::RegPatternLow: prdata = pat_reg[0];
            ssp_pkg::RegPatternSec: prdata = pat_reg[1];
            ssp_pkg::RegPatternThd: prdata = pat_reg[2];
            ssp_pkg::RegPatternHi:  prdata = pat_reg[3];
            default:                prdata = '0;
        endcase
    end

    assign cfg.length  = length_reg;
    assign cfg.pattern = {pat_reg[3], pat_reg[2], pat_reg[1], pat_reg[0]};

endmodule

### src/stream_seek_to_pattern.sv
// Each accepted byte's result is registered in the output register.
// Throughput: one byte per cycle while seeking or passing through, when the output
// is not stalled; a match holds the input while the rest of the span drains from the
// history cells through the single output register.
// Reset: asynchronous, active low; seeking armed, history empty, config registers zero.
module stream_seek_to_pattern (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      s_axis_tvalid,
    output logic                      s_axis_tready,
    input  logic [7:0]                s_axis_tdata,  // [7:0] data_byte
    input  logic                      s_axis_tuser,  // [0] kind
    output logic                      m_axis_tvalid,
    input  logic                      m_axis_tready,
    output logic [7:0]                m_axis_tdata,  // [7:0] out_byte
    output logic                      m_axis_tlast,  // last_of_run
    input  logic                      psel,
    input  logic                      penable,
    input  logic                      pwrite,
    input  logic [ssp_pkg::AddrW-1:0] paddr,
    input  logic [ssp_pkg::DataW-1:0] pwdata,
    output logic [ssp_pkg::DataW-1:0] prdata,
    output logic                      pready
);

    localparam int Depth = ssp_pkg::HistDepth;
    localparam int IdxW  = ssp_pkg::IdxW;
    localparam int LenW  = ssp_pkg::LenW;

    ssp_pkg::cfg_t cfg;

    logic [LenW-1:0] len_eff;
    logic [LenW-1:0] keep;
    logic [IdxW-1:0] keep_idx;
    logic [IdxW-1:0] last_idx;

    logic [7:0]      hist_q    [Depth];
    logic [7:0]      pat_align [Depth];
    logic [Depth-1:0] cell_hit;
    logic [Depth-1:0] cell_active;

    logic            seek_reg, seek_next;
    logic [IdxW-1:0] fill_reg, fill_next;
    logic            burst_reg, burst_next;
    logic [IdxW-1:0] bidx_reg, bidx_next;
    logic            oval_reg, oval_next;
    logic [7:0]      obyte_reg, obyte_next;
    logic            olast_reg, olast_next;

    logic            slot_free;
    logic            accept;
    logic            data_acc;
    logic            seeking;
    logic            hit;
    logic [LenW-1:0] fill_inc;

    ssp_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    assign len_eff  = (cfg.length > LenW'(ssp_pkg::PatternMax)) ?
                      LenW'(ssp_pkg::PatternMax) : cfg.length;
    assign keep     = (len_eff > LenW'(1)) ? (len_eff - LenW'(1)) : '0;
    assign keep_idx = keep[IdxW-1:0];
    assign last_idx = IdxW'(len_eff - LenW'(1));

    // cell j holds the j-th newest byte; line it up against the pattern tail
    genvar j;
    generate
        for (j = 0; j < Depth; j++)
        begin : g_cell
            logic [LenW-1:0] pidx;
            assign pidx           = keep - LenW'(1) - LenW'(j);
            assign cell_active[j] = (LenW'(j) < keep);
            assign pat_align[j]   = ssp_pkg::pattern_byte(cfg.pattern, pidx[IdxW-1:0]);

            if (j == 0)
            begin : g_head
                ssp_cell u_cell (
                    .clk      (clk),
                    .shift    (data_acc),
                    .byte_in  (s_axis_tdata),
                    .pat_byte (pat_align[j]),
                    .active   (cell_active[j]),
                    .byte_q   (hist_q[j]),
                    .hit      (cell_hit[j])
                );
            end
            else
            begin : g_body
                ssp_cell u_cell (
                    .clk      (clk),
                    .shift    (data_acc),
                    .byte_in  (hist_q[j-1]),
                    .pat_byte (pat_align[j]),
                    .active   (cell_active[j]),
                    .byte_q   (hist_q[j]),
                    .hit      (cell_hit[j])
                );
            end
        end
    endgenerate

    assign slot_free     = !oval_reg || m_axis_tready;
    assign s_axis_tready = !burst_reg && slot_free;
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign data_acc      = accept && (s_axis_tuser == ssp_pkg::KindData);
    assign seeking       = seek_reg && (len_eff != '0);
    assign hit           = (LenW'(fill_reg) >= keep) && (&cell_hit) &&
                           (ssp_pkg::pattern_byte(cfg.pattern, last_idx) == s_axis_tdata);
    assign fill_inc      = LenW'(fill_reg) + LenW'(1);

    always_comb
    begin
        seek_next  = seek_reg;
        fill_next  = fill_reg;
        burst_next = burst_reg;
        bidx_next  = bidx_reg;
        oval_next  = m_axis_tready ? 1'b0 : oval_reg;
        obyte_next = obyte_reg;
        olast_next = olast_reg;

        if (burst_reg && slot_free)
        begin
            // drain the matched span, oldest first
            oval_next  = 1'b1;
            obyte_next = hist_q[bidx_reg];
            olast_next = (bidx_reg == '0);
            if (bidx_reg == '0)
            begin
                burst_next = 1'b0;
            end
            else
            begin
                bidx_next = bidx_reg - IdxW'(1);
            end
        end

        if (accept && (s_axis_tuser == ssp_pkg::KindRearm))
        begin
            seek_next = 1'b1;
        end

        if (data_acc)
        begin
            fill_next = (fill_inc > keep) ? keep_idx : fill_inc[IdxW-1:0];
            if (!seeking)
            begin
                oval_next  = 1'b1;
                obyte_next = s_axis_tdata;
                olast_next = 1'b1;
            end
            else if (hit)
            begin
                seek_next = 1'b0;
                oval_next = 1'b1;
                if (keep == '0)
                begin
                    obyte_next = s_axis_tdata;
                    olast_next = 1'b1;
                end
                else
                begin
                    // oldest byte now; the rest sit at shifted places keep-1 .. 0
                    obyte_next = hist_q[keep_idx - IdxW'(1)];
                    olast_next = 1'b0;
                    burst_next = 1'b1;
                    bidx_next  = keep_idx - IdxW'(1);
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seek_reg  <= 1'b1;
            fill_reg  <= '0;
            burst_reg <= 1'b0;
            bidx_reg  <= '0;
            oval_reg  <= 1'b0;
        end
        else
        begin
            seek_reg  <= seek_next;
            fill_reg  <= fill_next;
            burst_reg <= burst_next;
            bidx_reg  <= bidx_next;
            oval_reg  <= oval_next;
        end
    end

    always_ff @(posedge clk)
    begin
        obyte_reg <= obyte_next;
        olast_reg <= olast_next;
    end

    assign m_axis_tvalid = oval_reg;
    assign m_axis_tdata  = obyte_reg;
    assign m_axis_tlast  = olast_reg;

endmodule

### tb/sv/testbench.sv
module testbench;

    localparam int WatchdogLimit = 4000;

    typedef struct packed {
        logic [7:0] data;
        logic       last;
    } out_beat_t;

    logic                          clk;
    logic                          rst_n;
    logic                          s_axis_tvalid;
    logic                          s_axis_tready;
    logic [7:0]                    s_axis_tdata;   // [7:0] data_byte
    logic                          s_axis_tuser;   // [0] kind
    logic                          m_axis_tvalid;
    logic                          m_axis_tready;
    logic [7:0]                    m_axis_tdata;   // [7:0] out_byte
    logic                          m_axis_tlast;   // last_of_run
    logic                          psel;
    logic                          penable;
    logic                          pwrite;
    logic [ssp_pkg::AddrW-1:0]     paddr;
    logic [ssp_pkg::DataW-1:0]     pwdata;
    logic [ssp_pkg::DataW-1:0]     prdata;
    logic                          pready;

    // filter model state
    logic [ssp_pkg::LenW-1:0]          pat_len_reg;
    logic [8*ssp_pkg::PatternMax-1:0]  pat_bits;
    logic [7:0]                        seen_bytes [ssp_pkg::PatternMax];
    int                                seen_count;
    bit                                armed;
    out_beat_t                         expected_beats [$];

    int         fail_count;
    int         items_sent;
    int         idle_cycles;
    int         hold_left;
    bit         gaps_on;
    bit         stall_on;
    logic [7:0] alpha_a;
    logic [7:0] alpha_b;

    stream_seek_to_pattern dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    initial clk = 1'b0;
    always #10 clk = ~clk;

    function automatic logic [7:0] pattern_at(input int idx);
        pattern_at = pat_bits[8*idx +: 8];
    endfunction

    function automatic void predict_filter(input logic kind, input logic [7:0] data);
        int  len;
        int  keep;
        bit  hit;
        out_beat_t beat;
        len  = (pat_len_reg > ssp_pkg::PatternMax) ? ssp_pkg::PatternMax : int'(pat_len_reg);
        keep = (len > 1) ? len - 1 : 0;
        if (kind == ssp_pkg::KindRearm)
        begin
            armed = 1'b1;
            return;
        end
        if (armed && len > 0)
        begin
            hit = (seen_count >= keep) && (pattern_at(len - 1) == data);
            for (int i = 0; i < keep; i++)
            begin
                if (pattern_at(i) != seen_bytes[keep - 1 - i])
                    hit = 1'b0;
            end
            if (hit)
            begin
                // emit the whole span, oldest byte first
                for (int i = 0; i < keep; i++)
                begin
                    beat.data = seen_bytes[keep - 1 - i];
                    beat.last = 1'b0;
                    expected_beats.push_back(beat);
                end
                beat.data = data;
                beat.last = 1'b1;
                expected_beats.push_back(beat);
                armed = 1'b0;
            end
        end
        else
        begin
            beat.data = data;
            beat.last = 1'b1;
            expected_beats.push_back(beat);
        end
        for (int i = ssp_pkg::PatternMax - 1; i > 0; i--)
            seen_bytes[i] = seen_bytes[i - 1];
        seen_bytes[0] = data;
        seen_count = (seen_count + 1 > keep) ? keep : seen_count + 1;
    endfunction

    function automatic void check_beat(input logic [7:0] data, input logic last);
        out_beat_t want;
        if (expected_beats.size() == 0)
        begin
            $error("unexpected transaction: out_byte %02h last_of_run %0b", data, last);
            fail_count++;
            return;
        end
        want = expected_beats.pop_front();
        if (data !== want.data)
        begin
            $error("out_byte: expected %02h, actual %02h", want.data, data);
            fail_count++;
        end
        if (last !== want.last)
        begin
            $error("last_of_run: expected %0b, actual %0b", want.last, last);
            fail_count++;
        end
    endfunction

    function automatic logic [7:0] noise_byte();
        case ($urandom_range(0, 3))
            0:       noise_byte = alpha_a;
            1:       noise_byte = alpha_b;
            default: noise_byte = 8'($urandom);
        endcase
    endfunction

    // pattern words drawn partly from the noise alphabet so noise often starts false prefixes
    function automatic logic [63:0] pattern_word();
        logic [63:0] word;
        for (int i = 0; i < 8; i++)
            word[8*i +: 8] = ($urandom_range(0, 3) == 0) ? 8'($urandom) : noise_byte();
        pattern_word = word;
    endfunction

    task automatic send_item(input logic kind, input logic [7:0] data);
        int gap;
        gap = gaps_on ? $urandom_range(0, 6) : 0;
        @(negedge clk);
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= data;
        s_axis_tuser  <= kind;
        do @(posedge clk); while (!s_axis_tready);
        predict_filter(kind, data);
        items_sent++;
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [63:0] value);
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 3'b000};
        pwdata  <= value;
        @(negedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        case (idx)
            ssp_pkg::RegLength:     pat_len_reg = value[ssp_pkg::LenW-1:0];
            ssp_pkg::RegPatternLow: pat_bits[63:0] = value;
            ssp_pkg::RegPatternSec: pat_bits[127:64] = value;
            ssp_pkg::RegPatternThd: pat_bits[191:128] = value;
            ssp_pkg::RegPatternHi:  pat_bits[255:192] = value;
            default:                ;
        endcase
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic drain_outputs();
        @(negedge clk);
        s_axis_tvalid <= 1'b0;
        while (expected_beats.size() != 0) @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic test_pass_through();
        gaps_on  = 1'b1;
        stall_on = 1'b1;
        send_item(ssp_pkg::KindData, 8'h00);
        send_item(ssp_pkg::KindData, 8'hFF);
        send_item(ssp_pkg::KindData, 8'hA5);
        send_item(ssp_pkg::KindData, 8'h5A);
        // rearm with no pattern still passes bytes
        send_item(ssp_pkg::KindRearm, 8'hFF);
        send_item(ssp_pkg::KindData, 8'h3C);
    endtask

    task automatic test_short_match();
        drain_outputs();
        write_reg(ssp_pkg::RegPatternLow, 64'h0000_0000_4443_4241);
        write_reg(ssp_pkg::RegLength, 64'd4);
        send_item(ssp_pkg::KindData, 8'h41);
        send_item(ssp_pkg::KindData, 8'h58);
        send_item(ssp_pkg::KindData, 8'h41);
        send_item(ssp_pkg::KindData, 8'h42);
        send_item(ssp_pkg::KindData, 8'h43);
        send_item(ssp_pkg::KindData, 8'h44);
        send_item(ssp_pkg::KindData, 8'h45);
        send_item(ssp_pkg::KindData, 8'h41);
        send_item(ssp_pkg::KindData, 8'h42);
        // history survives the rearm, so the match spans it
        send_item(ssp_pkg::KindRearm, 8'h00);
        send_item(ssp_pkg::KindData, 8'h43);
        send_item(ssp_pkg::KindData, 8'h44);
        send_item(ssp_pkg::KindData, 8'h44);
    endtask

    task automatic test_single_byte_pattern();
        drain_outputs();
        write_reg(ssp_pkg::RegPatternLow, 64'hFFFF_FFFF_FFFF_FFFF);
        write_reg(ssp_pkg::RegPatternHi, 64'hFFFF_FFFF_FFFF_FFFF);
        write_reg(ssp_pkg::RegLength, 64'd1);
        send_item(ssp_pkg::KindRearm, 8'h00);
        send_item(ssp_pkg::KindData, 8'h00);
        send_item(ssp_pkg::KindData, 8'hFF);
        send_item(ssp_pkg::KindData, 8'h00);
        send_item(ssp_pkg::KindRearm, 8'h55);
        send_item(ssp_pkg::KindRearm, 8'hAA);
        send_item(ssp_pkg::KindData, 8'h7E);
        send_item(ssp_pkg::KindData, 8'hFF);
    endtask

    task automatic test_random_phase(input int len, input bit gaps, input bit stalls,
                                     input int budget);
        int eff;
        int start;
        int k;
        drain_outputs();
        gaps_on  = gaps;
        stall_on = stalls;
        alpha_a  = 8'($urandom);
        alpha_b  = 8'($urandom);
        write_reg(ssp_pkg::RegPatternLow, pattern_word());
        write_reg(ssp_pkg::RegPatternSec, pattern_word());
        write_reg(ssp_pkg::RegPatternThd, pattern_word());
        write_reg(ssp_pkg::RegPatternHi, pattern_word());
        write_reg(ssp_pkg::RegLength, 64'(len));
        eff   = (len > ssp_pkg::PatternMax) ? ssp_pkg::PatternMax : len;
        start = items_sent;
        while (items_sent - start < budget)
        begin
            repeat ($urandom_range(0, 3)) send_item(ssp_pkg::KindData, noise_byte());
            // broken prefix: part of the pattern, then a stray byte
            if ($urandom_range(0, 2) == 0 && eff > 1)
            begin
                k = $urandom_range(1, eff - 1);
                for (int i = 0; i < k; i++)
                    send_item(ssp_pkg::KindData, pattern_at(i));
                send_item(ssp_pkg::KindData, noise_byte());
            end
            for (int i = 0; i < eff; i++)
                send_item(ssp_pkg::KindData, pattern_at(i));
            repeat ($urandom_range(0, 3)) send_item(ssp_pkg::KindData, noise_byte());
            if ($urandom_range(0, 4) != 0)
                send_item(ssp_pkg::KindRearm, 8'($urandom));
        end
    endtask

    task automatic test_output_backpressure();
        drain_outputs();
        gaps_on  = 1'b0;
        stall_on = 1'b1;
        write_reg(ssp_pkg::RegPatternLow, 64'h0000_0000_00C3_3C5A);
        write_reg(ssp_pkg::RegLength, 64'd3);
        hold_left = 150;
        send_item(ssp_pkg::KindData, 8'h5A);
        send_item(ssp_pkg::KindData, 8'h3C);
        send_item(ssp_pkg::KindData, 8'hC3);
        repeat (30) send_item(ssp_pkg::KindData, 8'($urandom));
    endtask

    // result sink: check each transaction, then pick the next stall
    initial
    begin : result_sink
        int sink_wait;
        sink_wait     = 0;
        m_axis_tready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (rst_n && m_axis_tvalid && m_axis_tready)
            begin
                check_beat(m_axis_tdata, m_axis_tlast);
                sink_wait = stall_on ? $urandom_range(0, 6) : 0;
            end
            @(negedge clk);
            if (hold_left > 0)
            begin
                hold_left--;
                m_axis_tready <= 1'b0;
            end
            else if (sink_wait > 0)
            begin
                sink_wait--;
                m_axis_tready <= 1'b0;
            end
            else
            begin
                m_axis_tready <= 1'b1;
            end
        end
    end

    always @(posedge clk)
    begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
            || (psel && penable))
        begin
            idle_cycles <= 0;
        end
        else if (idle_cycles >= WatchdogLimit)
        begin
            $display("TB_ERROR");
            $finish;
        end
        else
        begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial
    begin
        rst_n         = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = ssp_pkg::KindData;
        psel          = 1'b0;
        penable       = 1'b0;
        pwrite        = 1'b0;
        paddr         = '0;
        pwdata        = '0;
        pat_len_reg   = '0;
        pat_bits      = '0;
        for (int i = 0; i < ssp_pkg::PatternMax; i++)
            seen_bytes[i] = 8'h00;
        seen_count    = 0;
        armed         = 1'b1;
        fail_count    = 0;
        items_sent    = 0;
        hold_left     = 0;
        gaps_on       = 1'b1;
        stall_on      = 1'b1;
        alpha_a       = 8'h00;
        alpha_b       = 8'hFF;

        repeat (12) @(negedge clk);
        rst_n <= 1'b1;

        test_pass_through();
        test_short_match();
        test_single_byte_pattern();
        test_output_backpressure();
        test_random_phase(2, 1'b1, 1'b1, 12);
        test_random_phase(3, 1'b0, 1'b0, 12);
        test_random_phase(5, 1'b1, 1'b1, 12);
        test_random_phase(1, 1'b1, 1'b0, 12);
        test_random_phase(8, 1'b0, 1'b1, 12);
        test_random_phase(16, 1'b1, 1'b1, 12);
        test_random_phase(31, 1'b1, 1'b1, 12);
        test_random_phase(32, 1'b1, 1'b1, 12);
        test_random_phase(63, 1'b0, 1'b1, 12);
        test_random_phase(40, 1'b1, 1'b1, 12);
        test_random_phase($urandom_range(1, 32), 1'b1, 1'b1, 12);
        test_random_phase(0, 1'b1, 1'b1, 12);

        drain_outputs();
        repeat (40) @(posedge clk);
        if (fail_count == 0 && expected_beats.size() == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

### files.f
src/ssp_pkg.sv
src/ssp_cell.sv
src/ssp_cfg.sv
src/stream_seek_to_pattern.sv
tb/sv/testbench.sv
